[hw/rtl/wcb_pkg.sv]
//------------------------------------------------------------------------------
// wcb_pkg
// Types and constants shared by the windowed composition bias block.
//------------------------------------------------------------------------------
`default_nettype none
package wcb_pkg;
    localparam int unsigned COLS = 20;
    localparam int unsigned RING = 64;

    typedef enum logic [1:0] {
        CMD_LETTER = 2'd0,
        CMD_LOAD_MATRIX = 2'd1,
        CMD_LOAD_BG = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0] command;
        logic [4:0] letter;
        logic [4:0] column;
        logic signed [7:0] matrix_value;
        logic signed [15:0] background_value;
        logic last;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] correction;
        logic masked;
        logic end_of_run;
    } t_out_item;

    typedef struct packed {
        logic start;
        logic signed [31:0] dividend;
        logic [5:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
        logic signed [31:0] quotient;
    } t_div_rsp;
endpackage
`default_nettype wire

[hw/rtl/wcb_if.sv]
//------------------------------------------------------------------------------
// wcb_in_if / wcb_out_if
// Valid/ready channels carrying input and result transactions.
//------------------------------------------------------------------------------
`default_nettype none
interface wcb_in_if;
    logic valid;
    logic ready;
    wcb_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface wcb_out_if;
    logic valid;
    logic ready;
    wcb_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/windowed_composition_bias_unit.sv]
//------------------------------------------------------------------------------
// windowed_composition_bias_unit
// Per-position composition bias correction over a sliding residue window.
//------------------------------------------------------------------------------
// Letters enter one transaction at a time; the correction for a position
// leaves HALF_WIDTH letters later, and a letter marked last flushes the rest.
// One shared adder walks the 20 column sums behind the registered matrix read,
// for the added row and again for a dropped row, and a one-bit-per-cycle
// divider forms the window mean. A letter holds the input until its row
// update, any dropped row and any result are done; a letter marked last
// holds it through the flush. A masked position skips the divider. Loads are
// taken without leaving the idle state, and a stalled output holding a result
// keeps the input held too.
`default_nettype none
module windowed_composition_bias_unit #(
    parameter int HALF_WIDTH = 20,
    parameter int ALPHABET_ROWS = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    wcb_in_if.sink     i_in,
    wcb_out_if.source  o_out
);
    localparam int SPAN = 2 * HALF_WIDTH + 1;
    localparam int MDEPTH = ALPHABET_ROWS * 20;
    localparam int MAW = $clog2(MDEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_RING_RD, S_ROW_RD2, S_ROW, S_ROW_WAIT, S_EMIT_RD, S_EMIT_WAIT,
        S_SELF_RD, S_SELF_WAIT, S_EMIT_DIV, S_EMIT_DIVW, S_OUT, S_FLUSH_NEXT,
        S_FLUSH_STEP
    } t_state;

    t_state r_state;
    logic r_last;
    logic signed [13:0] r_sums [20];
    logic signed [15:0] r_bg [20];
    logic [6:0] r_count;
    logic [5:0] r_seen, r_head;
    logic [4:0] r_col;
    logic r_sub, r_after_drop, r_flush;
    logic [4:0] r_row;
    logic [5:0] r_fk, r_fn;
    logic [4:0] r_r;
    logic r_eor;
    logic signed [13:0] r_num;
    wcb_pkg::t_out_item r_res;
    wcb_pkg::t_out_item r_out;
    logic r_out_valid;

    // ring RAM
    logic ring_we;
    logic [5:0] ring_raddr, n_ring_raddr;
    logic [4:0] ring_rdata;
    // matrix RAM
    logic m_we;
    logic [MAW-1:0] m_waddr, m_raddr;
    logic [7:0] m_rdata;
    logic signed [7:0] m_score;

    wcb_pkg::t_div_req div_req;
    wcb_pkg::t_div_rsp div_rsp;

    wcb_ram #(.WIDTH(5), .DEPTH(wcb_pkg::RING)) u_ring (
        .i_clk(i_clk), .i_we(ring_we), .i_waddr(r_head),
        .i_wdata(i_in.data.letter), .i_raddr(n_ring_raddr), .o_rdata(ring_rdata));

    wcb_ram #(.WIDTH(8), .DEPTH(MDEPTH)) u_matrix (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_waddr),
        .i_wdata(i_in.data.matrix_value), .i_raddr(m_raddr), .o_rdata(m_rdata));

    wcb_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    logic accept;
    assign i_in.ready = (r_state == S_IDLE);
    assign accept = i_in.valid && i_in.ready;
    assign ring_we = accept && (i_in.data.command == wcb_pkg::CMD_LETTER);
    assign m_we = accept && (i_in.data.command == wcb_pkg::CMD_LOAD_MATRIX)
                  && (32'(i_in.data.letter) < ALPHABET_ROWS) && (i_in.data.column < 5'd20);
    assign m_waddr = MAW'(32'(i_in.data.letter) * 20 + 32'(i_in.data.column));
    assign n_ring_raddr = ring_raddr;

    logic row_ok;
    assign row_ok = 32'(r_row) < ALPHABET_ROWS;
    always_comb begin
        m_raddr = MAW'(32'(r_row) * 20 + 32'(r_col));
        if (r_state == S_SELF_RD) begin
            m_raddr = MAW'(32'(r_r) * 20 + 32'(r_r));
        end
    end
    assign m_score = row_ok ? $signed(m_rdata) : 8'sd0;

    // shared adder
    logic signed [13:0] acc_sum;
    assign acc_sum = r_sub ? r_sums[r_col] - 14'(m_score) : r_sums[r_col] + 14'(m_score);

    // ring read address choice
    logic [5:0] drop_addr, emit_addr, flush_addr;
    assign drop_addr = 6'(r_head - 6'(SPAN));
    assign emit_addr = 6'(r_head - 6'(HALF_WIDTH));
    assign flush_addr = 6'(r_head - r_fn + r_fk);

    logic [5:0] f_drop_addr;
    assign f_drop_addr = 6'(7'(r_head) - r_count);

    always_comb begin
        ring_raddr = emit_addr;
        if (r_flush) begin
            ring_raddr = (r_state == S_RING_RD) ? f_drop_addr : flush_addr;
        end else if (r_state == S_RING_RD) begin
            ring_raddr = drop_addr;
        end
    end

    logic signed [31:0] q_v;
    logic signed [17:0] v;
    assign q_v = div_rsp.quotient;

    always_comb begin
        div_req.start = (r_state == S_EMIT_DIV);
        div_req.dividend = 32'(r_num) <<< 8;
        div_req.divisor = 6'(r_count - 7'd1);
    end

    logic signed [32:0] n_v;
    assign n_v = 33'(r_bg[r_r]) - 33'(q_v);
    assign v = (n_v > 33'sd32767) ? 18'sd32767 : (n_v < -33'sd32768) ? -18'sd32768 : 18'(n_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_seen <= '0;
            r_head <= '0;
            r_out_valid <= 1'b0;
            r_flush <= 1'b0;
            for (int i = 0; i < 20; i++) r_sums[i] <= '0;
        end else begin
            if (r_state == S_OUT && (!r_out_valid || o_out.ready)) r_out_valid <= 1'b1;
            else if (o_out.ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_last <= i_in.data.last;
                        case (i_in.data.command)
                            wcb_pkg::CMD_LOAD_BG: begin
                                if (i_in.data.letter < 5'd20)
                                    r_bg[i_in.data.letter] <= i_in.data.background_value;
                            end
                            wcb_pkg::CMD_LETTER: begin
                                r_row <= i_in.data.letter;
                                r_sub <= 1'b0;
                                r_col <= '0;
                                r_after_drop <= 1'b0;
                                r_count <= r_count + 7'd1;
                                r_state <= S_ROW_WAIT;
                            end
                            default: ;
                        endcase
                    end
                end
                S_ROW_WAIT: r_state <= S_ROW;
                S_ROW: begin
                    r_sums[r_col] <= acc_sum;
                    if (r_col == 5'd19) begin
                        r_col <= '0;
                        if (r_flush) begin
                            r_count <= r_count - 7'd1;
                            r_state <= S_EMIT_RD;
                        end else if (!r_after_drop && 32'(r_count) > SPAN) begin
                            r_after_drop <= 1'b1;
                            r_state <= S_RING_RD;
                        end else begin
                            if (r_after_drop) r_count <= r_count - 7'd1;
                            r_state <= (32'(r_seen) >= HALF_WIDTH) ? S_EMIT_RD : S_FLUSH_NEXT;
                            r_eor <= 1'b0;
                        end
                    end else begin
                        r_col <= r_col + 5'd1;
                        r_state <= S_ROW_WAIT;
                    end
                end
                S_RING_RD: r_state <= S_ROW_RD2;
                S_ROW_RD2: begin
                    r_row <= ring_rdata;
                    r_sub <= 1'b1;
                    r_col <= '0;
                    r_state <= S_ROW_WAIT;
                end
                S_EMIT_RD: r_state <= S_EMIT_WAIT;
                S_EMIT_WAIT: begin
                    r_r <= ring_rdata;
                    r_state <= S_SELF_RD;
                end
                S_SELF_RD: r_state <= S_SELF_WAIT;
                S_SELF_WAIT: begin
                    r_num <= r_sums[r_r] - 14'(((32'(r_r) < ALPHABET_ROWS)) ? $signed(m_rdata) : 8'sd0);
                    if (r_r >= 5'd20) begin
                        r_res.correction <= '0;
                        r_res.masked <= 1'b1;
                        r_res.end_of_run <= r_eor;
                        r_state <= S_OUT;
                    end else r_state <= S_EMIT_DIV;
                end
                S_EMIT_DIV: r_state <= S_EMIT_DIVW;
                S_EMIT_DIVW: begin
                    if (r_count <= 7'd1) begin
                        r_res.correction <= r_bg[r_r];
                        r_res.masked <= 1'b0;
                        r_res.end_of_run <= r_eor;
                        r_state <= S_OUT;
                    end else if (div_rsp.done) begin
                        r_res.correction <= 16'(v);
                        r_res.masked <= 1'b0;
                        r_res.end_of_run <= r_eor;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out <= r_res;
                        r_state <= S_FLUSH_NEXT;
                    end
                end
                S_FLUSH_NEXT: begin
                    if (!r_flush) begin
                        r_head <= r_head + 6'd1;
                        if (r_seen < 6'd63) r_seen <= r_seen + 6'd1;
                        if (r_last) begin
                            r_flush <= 1'b1;
                            r_fk <= '0;
                            r_fn <= (32'(r_seen) + 1 < HALF_WIDTH) ? r_seen + 6'd1
                                    : 6'(HALF_WIDTH);
                            r_state <= S_FLUSH_STEP;
                        end else r_state <= S_IDLE;
                    end else if (r_fk + 6'd1 == r_fn) begin
                        r_flush <= 1'b0;
                        r_count <= '0;
                        r_seen <= '0;
                        r_head <= '0;
                        for (int i = 0; i < 20; i++) r_sums[i] <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_fk <= r_fk + 6'd1;
                        r_state <= S_FLUSH_STEP;
                    end
                end
                S_FLUSH_STEP: begin
                    r_eor <= (r_fk + 6'd1 == r_fn);
                    if (32'(r_count) > HALF_WIDTH + 1) r_state <= S_RING_RD;
                    else r_state <= S_EMIT_RD;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data = r_out;
endmodule
`default_nettype wire

[hw/rtl/wcb_ram.sv]
//------------------------------------------------------------------------------
// wcb_ram
// Generic single-port-write, single-read RAM with registered read data.
//------------------------------------------------------------------------------
`default_nettype none
module wcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[hw/rtl/wcb_div.sv]
//------------------------------------------------------------------------------
// wcb_div
// Restoring signed divider, one quotient bit per cycle, truncating to zero.
//------------------------------------------------------------------------------
`default_nettype none
module wcb_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire wcb_pkg::t_div_req i_req,
    output wcb_pkg::t_div_rsp      o_rsp
);
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [5:0]  r_den;
    logic [5:0]  r_cnt;
    logic        r_neg;
    logic        r_busy;
    logic        r_done;
    logic [32:0] n_trial;

    assign n_trial = {r_rem, r_quo[31]} - {27'd0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_quo  <= i_req.dividend[31] ? 32'(-i_req.dividend) : i_req.dividend;
                r_neg  <= i_req.dividend[31];
                r_den  <= i_req.divisor;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (!n_trial[32]) begin
                    r_rem <= n_trial[31:0];
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[30:0], r_quo[31]};
                    r_quo <= {r_quo[30:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quotient = r_neg ? 32'(-r_quo) : r_quo;
endmodule
`default_nettype wire

[test/tb_windowed_composition_bias_unit.sv]
//------------------------------------------------------------------------------
// tb_windowed_composition_bias_unit
// Self-checking bench for the windowed composition bias unit. Loads the
// substitution rows of the letters in use, the background scores of the unmasked
// ones, runs directed letter sequences, then random sequences with random idling
// on both channels, and checks every correction against an in-bench predictor.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_windowed_composition_bias_unit;

    localparam int HALF = 20;
    localparam int SPAN = 2 * HALF + 1;
    localparam int NROWS = 32;
    localparam int RING = wcb_pkg::RING;
    localparam int COLS = wcb_pkg::COLS;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #6 i_clk = ~i_clk;

    wcb_in_if  in_ch ();
    wcb_out_if out_ch ();

    windowed_composition_bias_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // predictor state
    logic [4:0]         pr_ring [RING];
    int                 pr_sums [COLS];
    logic signed [7:0]  pr_subst [NROWS][COLS];
    logic signed [15:0] pr_bg [COLS];
    int                 pr_count, pr_seen, pr_head;

    wcb_pkg::t_out_item corr_queue [$];
    int        n_err = 0;
    int        n_sent = 0;
    int        n_got = 0;
    int        n_masked = 0;
    int        n_runs = 0;
    int        stall_cnt = 0;
    bit        idle_on = 1'b1;
    int        letter_set [6] = '{0, 5, 19, 20, 25, 31};

    function automatic int score(int r, int c);
        if (r >= NROWS || c >= COLS) return 0;
        return int'(pr_subst[r][c]);
    endfunction

    function automatic void add_row(int r, int sgn);
        for (int c = 0; c < COLS; c++) pr_sums[c] += sgn * score(r, c);
    endfunction

    function automatic void push_corr(int r, int n, bit eor);
        wcb_pkg::t_out_item o;
        int num, q, v;
        o = '0;
        o.end_of_run = eor;
        if (r >= COLS) begin
            o.masked = 1'b1;
        end else begin
            num = pr_sums[r] - score(r, r);
            q = (n > 1) ? (num * 256) / (n - 1) : 0;
            v = int'(pr_bg[r]) - q;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            o.correction = v[15:0];
        end
        corr_queue.push_back(o);
    endfunction

    function automatic void predict_bias(wcb_pkg::t_in_item it);
        int f, r;
        case (wcb_pkg::t_cmd'(it.command))
            wcb_pkg::CMD_LOAD_MATRIX:
                if (it.column < COLS) pr_subst[it.letter][it.column] = it.matrix_value;
            wcb_pkg::CMD_LOAD_BG: if (it.letter < COLS) pr_bg[it.letter] = it.background_value;
            wcb_pkg::CMD_LETTER: begin
                pr_ring[pr_head] = it.letter;
                add_row(it.letter, 1);
                pr_count++;
                if (pr_count > SPAN) begin
                    add_row(pr_ring[(pr_head + RING - SPAN) % RING], -1);
                    pr_count--;
                end
                if (pr_seen >= HALF) push_corr(pr_ring[(pr_head + RING - HALF) % RING], pr_count, 0);
                pr_head = (pr_head + 1) % RING;
                if (pr_seen < 63) pr_seen++;
                if (it.last) begin
                    f = pr_seen < HALF ? pr_seen : HALF;
                    for (int k = 0; k < f; k++) begin
                        r = pr_ring[(pr_head + RING - f + k) % RING];
                        if (pr_count > HALF + 1) begin
                            add_row(pr_ring[(pr_head + RING - pr_count) % RING], -1);
                            pr_count--;
                        end
                        push_corr(r, pr_count, k + 1 == f);
                    end
                    foreach (pr_sums[c]) pr_sums[c] = 0;
                    pr_count = 0;
                    pr_seen = 0;
                    pr_head = 0;
                    n_runs++;
                end
            end
            default: ;
        endcase
    endfunction

    task automatic send_item(wcb_pkg::t_in_item it);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_bias(it);
        n_sent++;
    endtask

    function automatic wcb_pkg::t_in_item mk(wcb_pkg::t_cmd cmd, int ltr, int col, int mv,
                                             int bv, bit lst);
        wcb_pkg::t_in_item it;
        it.command = cmd;
        it.letter = ltr[4:0];
        it.column = col[4:0];
        it.matrix_value = mv[7:0];
        it.background_value = bv[15:0];
        it.last = lst;
        return it;
    endfunction

    task automatic drain_wait();
        in_ch.valid <= 1'b0;
        while (corr_queue.size() != 0) @(posedge i_clk);
    endtask

    // sink side: random stall bursts, check on handshake
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                n_got++;
                if (corr_queue.size() == 0) begin
                    $error("unexpected transaction %p", out_ch.data);
                    n_err++;
                end else begin
                    wcb_pkg::t_out_item e;
                    e = corr_queue.pop_front();
                    if (e.masked) n_masked++;
                    if (out_ch.data.correction !== e.correction) begin
                        $error("correction: expected %0d got %0d", e.correction,
                               out_ch.data.correction);
                        n_err++;
                    end
                    if (out_ch.data.masked !== e.masked) begin
                        $error("masked: expected %0b got %0b", e.masked, out_ch.data.masked);
                        n_err++;
                    end
                    if (out_ch.data.end_of_run !== e.end_of_run) begin
                        $error("end_of_run: expected %0b got %0b", e.end_of_run,
                               out_ch.data.end_of_run);
                        n_err++;
                    end
                end
            end
            if (stall_cnt > 0) begin
                out_ch.ready <= 1'b0;
                stall_cnt <= stall_cnt - 1;
            end else if (idle_on && $urandom_range(0, 15) == 0) begin
                out_ch.ready <= 1'b0;
                stall_cnt <= $urandom_range(0, 18);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    typedef struct {
        wcb_pkg::t_in_item  item;
        bit                 chk;
        wcb_pkg::t_out_item exp_o;
    } t_row;

    initial begin
        t_row rows [$];
        wcb_pkg::t_in_item it;
        int len;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        pr_count = 0;
        pr_seen = 0;
        pr_head = 0;
        foreach (pr_sums[c]) pr_sums[c] = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // table rows of every letter in use, background scores of the unmasked ones
        for (int i = 0; i < 6; i++)
            for (int c = 0; c < COLS; c++)
                send_item(mk(wcb_pkg::CMD_LOAD_MATRIX, letter_set[i], c,
                             $urandom_range(0, 255), 0, $urandom_range(0, 1)));
        for (int i = 0; i < 3; i++)
            send_item(mk(wcb_pkg::CMD_LOAD_BG, letter_set[i], 0, 0, $urandom_range(0, 65535), 0));

        // directed: ignored loads, unused command, extreme values
        rows.push_back('{mk(wcb_pkg::CMD_LOAD_MATRIX, 3, 20, 8'h7f, 0, 0), 0, '0});
        rows.push_back('{mk(wcb_pkg::CMD_LOAD_MATRIX, 31, 31, 8'h80, 16'hffff, 1), 0, '0});
        rows.push_back('{mk(wcb_pkg::CMD_LOAD_BG, 20, 31, 0, 16'h8000, 0), 0, '0});
        rows.push_back('{mk(wcb_pkg::CMD_LOAD_BG, 31, 0, 8'hff, 16'h7fff, 1), 0, '0});
        rows.push_back('{mk(wcb_pkg::CMD_NONE, 31, 31, 8'hff, 16'hffff, 1), 0, '0});
        rows.push_back('{mk(wcb_pkg::CMD_LOAD_BG, 0, 0, 0, 32767, 0), 0, '0});
        rows.push_back('{mk(wcb_pkg::CMD_LOAD_BG, 19, 0, 0, -32768, 0), 0, '0});
        rows.push_back('{mk(wcb_pkg::CMD_LOAD_MATRIX, 19, 0, -128, 0, 0), 0, '0});
        rows.push_back('{mk(wcb_pkg::CMD_LOAD_MATRIX, 0, 19, 127, 0, 0), 0, '0});
        // one-letter sequences: result equals background score, or is masked for letters 20 and 31
        rows.push_back('{mk(wcb_pkg::CMD_LETTER, 0, 0, 0, 0, 1), 1, '{16'sh7fff, 1'b0, 1'b1}});
        rows.push_back('{mk(wcb_pkg::CMD_LETTER, 19, 0, 0, 0, 1), 1, '{16'sh8000, 1'b0, 1'b1}});
        rows.push_back('{mk(wcb_pkg::CMD_LETTER, 31, 31, 0, 0, 1), 1, '{16'sh0000, 1'b1, 1'b1}});
        rows.push_back('{mk(wcb_pkg::CMD_LETTER, 20, 0, 0, 0, 1), 1, '{16'sh0000, 1'b1, 1'b1}});
        // short sequence mixing masked and real letters
        rows.push_back('{mk(wcb_pkg::CMD_LETTER, 5, 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk(wcb_pkg::CMD_LETTER, 25, 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk(wcb_pkg::CMD_LETTER, 19, 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk(wcb_pkg::CMD_LETTER, 0, 0, 0, 0, 1), 0, '0});
        foreach (rows[i]) begin
            if (rows[i].chk) begin
                send_item(rows[i].item);
                if (corr_queue[$] != rows[i].exp_o) begin
                    $error("correction: expected %p got %p", rows[i].exp_o, corr_queue[$]);
                    n_err++;
                end
            end else begin
                send_item(rows[i].item);
            end
        end
        drain_wait();

        // random sequences, some long enough to fill and slide the window
        while (n_sent < 235) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(42, 50) : $urandom_range(1, 25);
            if (n_sent > 200) idle_on = 1'b0;
            for (int k = 0; k < len; k++) begin
                case ($urandom_range(0, 19))
                    0: send_item(mk(wcb_pkg::CMD_LOAD_MATRIX, $urandom_range(0, 31),
                                    $urandom_range(0, 31), $urandom_range(0, 255), $urandom,
                                    $urandom_range(0, 1)));
                    1: send_item(mk(wcb_pkg::CMD_LOAD_BG, $urandom_range(0, 31),
                                    $urandom_range(0, 31), $urandom, $urandom_range(0, 65535),
                                    $urandom_range(0, 1)));
                    2: send_item(mk(wcb_pkg::CMD_NONE, $urandom, $urandom, $urandom, $urandom, 1));
                    default: ;
                endcase
                it = mk(wcb_pkg::CMD_LETTER, ($urandom_range(0, 9) == 0)
                        ? letter_set[$urandom_range(3, 5)] : letter_set[$urandom_range(0, 2)],
                        $urandom_range(0, 31), $urandom, $urandom, k == len - 1);
                send_item(it);
            end
            if ($urandom_range(0, 4) == 0) drain_wait();
        end
        drain_wait();
        repeat (200) @(posedge i_clk);
        $display("sent %0d input transactions, %0d sequences", n_sent, n_runs);
        $display("checked %0d corrections, %0d of them masked", n_got, n_masked);
        if (n_err == 0 && corr_queue.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #60ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire
